### hdl/pcci_pkg.sv
// ----------------------------------------------------------------------------
// pcci_pkg
// shared codes and fixed widths of the point cloud costmap inflation block
// ----------------------------------------------------------------------------
package pcci_pkg;

  // item kinds
  localparam logic [1:0] KIND_POINT   = 2'd0;
  localparam logic [1:0] KIND_INFLATE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_CELL_SIZE = 3'd0;
  localparam logic [2:0] REG_GRID      = 3'd1;
  localparam logic [2:0] REG_Z_MIN     = 3'd2;
  localparam logic [2:0] REG_Z_MAX     = 3'd3;
  localparam logic [2:0] REG_RADIUS    = 3'd4;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [6:0] COST_MAX = 7'd100;
  localparam int         COST_SQ  = 10000;

  typedef logic [6:0] cost_t;

endpackage

### hdl/point_cloud_costmap_inflation_top.sv
// ----------------------------------------------------------------------------
// point_cloud_costmap_inflation_top
// occupancy grid from 3d points with linear-decay cost inflation
// ----------------------------------------------------------------------------
// One item is taken at a time. After reset the core and cost maps are swept
// to zero, one entry a cycle, over all MAX_GRID*MAX_GRID entries, before the
// first item is taken. A point (kind 0) runs a prepare step, a range check,
// the shift-subtract cell divider and a core map write. A read (kind 2) goes
// through the cost memory port. A clear (kind 3) sweeps both maps, one entry
// a cycle. An inflate (kind 1) first finds the window size, then for each of
// the (n+1)^2 kernel offsets runs the ceiling search, then sweeps the cost
// map to zero, then scans every grid cell and, around each core cell, every
// window offset with a read-modify-write of the cost map.
module point_cloud_costmap_inflation_top #(
  parameter int MAX_GRID            = 64,
  parameter int MAX_INFLATION_CELLS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [63:0]                s_tdata,   // x_mm, y_mm, z_mm, cell_col, cell_row
  input  logic [1:0]                 s_tuser,   // kind
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // cost
  output logic [1:0]                 m_tuser,   // done_kind
  input  logic                       cfg_we,
  input  logic [pcci_pkg::CFG_IW-1:0] cfg_index,
  input  logic [pcci_pkg::CFG_DW-1:0] cfg_data
);

  localparam int CELLS = MAX_GRID * MAX_GRID;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(MAX_GRID);
  localparam int GCW   = $clog2(MAX_GRID + 1);
  localparam int NW    = $clog2(MAX_INFLATION_CELLS + 1);
  localparam int KN    = MAX_INFLATION_CELLS + 1;
  localparam int KD    = KN * KN;
  localparam int KAW   = $clog2(KD);
  localparam int D2W   = 2 * NW + 1;
  localparam int CDW   = 20 + D2W;
  localparam int WW    = 44 + D2W;
  localparam int SPW   = GCW + 10;
  localparam int NUMW  = SPW + 6;
  localparam int DW    = 11 + XW;
  localparam int DSW   = $clog2(XW + 1);
  localparam int SNW   = ((XW > NW) ? XW : NW) + 2;

  localparam logic [4:0] S_RCLR  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_PPREP = 5'd2;
  localparam logic [4:0] S_PCHK  = 5'd3;
  localparam logic [4:0] S_PDIV  = 5'd4;
  localparam logic [4:0] S_PWR   = 5'd5;
  localparam logic [4:0] S_RDA   = 5'd6;
  localparam logic [4:0] S_RDB   = 5'd7;
  localparam logic [4:0] S_CLR   = 5'd8;
  localparam logic [4:0] S_INFN  = 5'd9;
  localparam logic [4:0] S_K0    = 5'd10;
  localparam logic [4:0] S_K1    = 5'd11;
  localparam logic [4:0] S_K2    = 5'd12;
  localparam logic [4:0] S_K3    = 5'd13;
  localparam logic [4:0] S_ICLR  = 5'd14;
  localparam logic [4:0] S_SCRD  = 5'd15;
  localparam logic [4:0] S_SCCHK = 5'd16;
  localparam logic [4:0] S_SCOFF = 5'd17;
  localparam logic [4:0] S_SCUPD = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] r, input logic [XW-1:0] c);
    cell_addr = AW'(r) * AW'(MAX_GRID) + AW'(c);
  endfunction

  // configuration
  logic [9:0]         cell_size;
  logic [6:0]         grid_cells;
  logic signed [15:0] z_min;
  logic signed [15:0] z_max;
  logic [13:0]        radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size  <= 10'd50;
      grid_cells <= 7'd50;
      z_min      <= 16'sd100;
      z_max      <= 16'sd1000;
      radius     <= 14'd400;
    end else if (cfg_we) begin
      case (cfg_index)
        pcci_pkg::REG_CELL_SIZE: cell_size  <= cfg_data[9:0];
        pcci_pkg::REG_GRID:      grid_cells <= cfg_data[6:0];
        pcci_pkg::REG_Z_MIN:     z_min      <= $signed(cfg_data);
        pcci_pkg::REG_Z_MAX:     z_max      <= $signed(cfg_data);
        pcci_pkg::REG_RADIUS:    radius     <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  logic [9:0]     cu;
  logic [GCW-1:0] gu;
  logic [SPW-1:0] span_c;
  assign cu     = (cell_size == 10'd0) ? 10'd1 : cell_size;
  assign gu     = (int'(grid_cells) > MAX_GRID) ? GCW'(MAX_GRID) : GCW'(grid_cells);
  assign span_c = SPW'(gu) * SPW'(cu);

  // memories
  logic                  core_mem [CELLS];
  pcci_pkg::cost_t       cost_mem [CELLS];
  logic [7:0]            kern_mem [KD];
  logic                  core_q;
  pcci_pkg::cost_t       cost_q;
  logic [7:0]            kern_q;
  logic [AW-1:0]         core_ra, cost_ra;
  logic [KAW-1:0]        kern_ra;
  logic                  core_we, cost_we, kern_we;
  logic [AW-1:0]         core_wa, cost_wa;
  logic                  core_wd;
  pcci_pkg::cost_t       cost_wd;
  logic [KAW-1:0]        kern_wa;
  logic [7:0]            kern_wd;

  always_ff @(posedge clk) begin
    if (core_we) core_mem[core_wa] <= core_wd;
    core_q <= core_mem[core_ra];
  end
  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    cost_q <= cost_mem[cost_ra];
  end
  always_ff @(posedge clk) begin
    if (kern_we) kern_mem[kern_wa] <= kern_wd;
    kern_q <= kern_mem[kern_ra];
  end

  // control and working registers
  logic [4:0]            state;
  logic [1:0]            kind;
  pcci_pkg::cost_t       res_cost;
  logic [AW-1:0]         clr_addr;
  logic signed [15:0]    px, py, pz;
  logic [5:0]            rd_col, rd_row;
  logic                  zok;
  logic signed [NUMW-1:0] numx, numy;
  logic [SPW:0]          span2;
  logic [DW-1:0]         remx, remy, dsh;
  logic [XW-1:0]         qx, qy;
  logic [DSW-1:0]        div_cnt;
  logic [NW-1:0]         win_n;
  logic [16:0]           win_acc;
  logic [19:0]           c2;
  logic [27:0]           r2;
  logic [NW-1:0]         adx, ady;
  logic [D2W-1:0]        d2;
  logic [CDW-1:0]        cd;
  logic                  in_radius;
  logic [WW-1:0]         lim, acc_s, acc_t;
  logic [6:0]            kcnt;
  logic [XW-1:0]         sx, sy;
  logic signed [NW:0]    dx, dy;
  logic [AW-1:0]         upd_addr;

  // scan helpers
  logic signed [SNW-1:0] nx, ny;
  logic                  nb_in;
  logic [NW-1:0]         abx, aby;
  logic                  cell_last, row_last, col_last, off_last, offx_last;
  logic                  out_free;

  assign nx    = $signed(SNW'(sx)) + SNW'(dx);
  assign ny    = $signed(SNW'(sy)) + SNW'(dy);
  assign nb_in = !nx[SNW-1] && !ny[SNW-1] &&
                 (nx < $signed(SNW'(gu))) && (ny < $signed(SNW'(gu)));
  assign abx   = dx[NW] ? NW'(-dx) : NW'(dx);
  assign aby   = dy[NW] ? NW'(-dy) : NW'(dy);
  assign col_last  = (GCW'(sx) + GCW'(1)) == gu;
  assign row_last  = (GCW'(sy) + GCW'(1)) == gu;
  assign cell_last = col_last && row_last;
  assign offx_last = dx == $signed({1'b0, win_n});
  assign off_last  = offx_last && (dy == $signed({1'b0, win_n}));
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);

  always_comb begin
    core_ra = '0;
    cost_ra = '0;
    kern_ra = '0;
    core_we = 1'b0;
    core_wa = clr_addr;
    core_wd = 1'b0;
    cost_we = 1'b0;
    cost_wa = clr_addr;
    cost_wd = '0;
    kern_we = 1'b0;
    kern_wa = KAW'(ady) * KAW'(KN) + KAW'(adx);
    kern_wd = {in_radius, 7'(pcci_pkg::COST_MAX - kcnt)};
    case (state)
      S_RCLR, S_CLR: begin
        core_we = 1'b1;
        cost_we = 1'b1;
      end
      S_ICLR: cost_we = 1'b1;
      S_PWR: begin
        core_we = 1'b1;
        core_wa = cell_addr(qy, qx);
        core_wd = 1'b1;
      end
      S_RDA: cost_ra = cell_addr(XW'(rd_row), XW'(rd_col));
      S_K3: kern_we = !((kcnt < pcci_pkg::COST_MAX) && (acc_s < lim));
      S_SCRD: core_ra = cell_addr(sy, sx);
      S_SCOFF: begin
        cost_ra = cell_addr(XW'(ny), XW'(nx));
        kern_ra = KAW'(aby) * KAW'(KN) + KAW'(abx);
      end
      S_SCUPD: begin
        cost_we = kern_q[7] && (kern_q[6:0] > cost_q);
        cost_wa = upd_addr;
        cost_wd = kern_q[6:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RCLR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_RCLR, S_CLR, S_ICLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) begin
            clr_addr <= '0;
            if (state == S_RCLR) begin
              state <= S_IDLE;
            end else if (state == S_CLR) begin
              state <= S_DONE;
            end else begin
              sx <= '0;
              sy <= '0;
              state <= (gu == '0) ? S_DONE : S_SCRD;
            end
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            kind     <= s_tuser;
            res_cost <= '0;
            px       <= $signed(s_tdata[15:0]);
            py       <= $signed(s_tdata[31:16]);
            pz       <= $signed(s_tdata[47:32]);
            rd_col   <= s_tdata[53:48];
            rd_row   <= s_tdata[59:54];
            win_n    <= '0;
            win_acc  <= '0;
            case (s_tuser)
              pcci_pkg::KIND_POINT:   state <= S_PPREP;
              pcci_pkg::KIND_INFLATE: state <= S_INFN;
              pcci_pkg::KIND_READ:    state <= S_RDA;
              default:                state <= S_CLR;
            endcase
          end
        end
        S_PPREP: begin
          zok   <= (pz >= z_min) && (pz <= z_max);
          numx  <= ($signed(NUMW'(px)) <<< 1) + $signed(NUMW'(span_c));
          numy  <= ($signed(NUMW'(py)) <<< 1) + $signed(NUMW'(span_c));
          span2 <= {span_c, 1'b0};
          state <= S_PCHK;
        end
        S_PCHK: begin
          remx    <= DW'(numx);
          remy    <= DW'(numy);
          dsh     <= DW'({cu, 1'b0}) << (XW - 1);
          div_cnt <= DSW'(XW);
          if (zok && !numx[NUMW-1] && !numy[NUMW-1] &&
              (numx < $signed(NUMW'(span2))) && (numy < $signed(NUMW'(span2))))
            state <= S_PDIV;
          else
            state <= S_IDLE;
        end
        S_PDIV: begin
          if (remx >= dsh) remx <= remx - dsh;
          if (remy >= dsh) remy <= remy - dsh;
          qx      <= {qx[XW-2:0], remx >= dsh};
          qy      <= {qy[XW-2:0], remy >= dsh};
          dsh     <= dsh >> 1;
          div_cnt <= div_cnt - DSW'(1);
          if (div_cnt == DSW'(1)) state <= S_PWR;
        end
        S_PWR: state <= S_IDLE;
        S_RDA: state <= S_RDB;
        S_RDB: begin
          if ((GCW'(rd_col) < gu) && (GCW'(rd_row) < gu) &&
              (int'(rd_col) < MAX_GRID) && (int'(rd_row) < MAX_GRID))
            res_cost <= cost_q;
          state <= S_DONE;
        end
        // window size: ceil(radius / cell) by repeated addition, clamped
        S_INFN: begin
          c2 <= 20'(cu) * 20'(cu);
          r2 <= 28'(radius) * 28'(radius);
          adx <= '0;
          ady <= '0;
          if ((win_acc >= 17'(radius)) || (int'(win_n) == MAX_INFLATION_CELLS)) begin
            state <= S_K0;
          end else begin
            win_acc <= win_acc + 17'(cu);
            win_n   <= win_n + NW'(1);
          end
        end
        S_K0: begin
          d2    <= D2W'(adx) * D2W'(adx) + D2W'(ady) * D2W'(ady);
          state <= S_K1;
        end
        S_K1: begin
          cd    <= CDW'(c2) * CDW'(d2);
          state <= S_K2;
        end
        S_K2: begin
          in_radius <= CDW'(r2) >= cd;
          lim    <= WW'(cd) * WW'(pcci_pkg::COST_SQ);
          acc_s  <= '0;
          acc_t  <= WW'(r2);
          kcnt   <= '0;
          state  <= S_K3;
        end
        // smallest k with (k*r)^2 >= 10000*c^2*d2, squares built by odd steps
        S_K3: begin
          if ((kcnt < pcci_pkg::COST_MAX) && (acc_s < lim)) begin
            acc_s <= acc_s + acc_t;
            acc_t <= acc_t + (WW'(r2) << 1);
            kcnt  <= kcnt + 7'd1;
          end else if (adx == win_n) begin
            adx <= '0;
            if (ady == win_n) begin
              state <= S_ICLR;
            end else begin
              ady   <= ady + NW'(1);
              state <= S_K0;
            end
          end else begin
            adx   <= adx + NW'(1);
            state <= S_K0;
          end
        end
        S_SCRD: state <= S_SCCHK;
        S_SCCHK: begin
          dx <= -$signed({1'b0, win_n});
          dy <= -$signed({1'b0, win_n});
          if (core_q) begin
            state <= S_SCOFF;
          end else begin
            state <= cell_last ? S_DONE : S_SCRD;
            sx <= col_last ? '0 : sx + XW'(1);
            if (col_last) sy <= sy + XW'(1);
          end
        end
        S_SCOFF, S_SCUPD: begin
          upd_addr <= cell_addr(XW'(ny), XW'(nx));
          if (state == S_SCOFF && nb_in) begin
            state <= S_SCUPD;
          end else if (off_last) begin
            state <= cell_last ? S_DONE : S_SCRD;
            sx <= col_last ? '0 : sx + XW'(1);
            if (col_last) sy <= sy + XW'(1);
          end else begin
            state <= S_SCOFF;
            if (offx_last) begin
              dx <= -$signed({1'b0, win_n});
              dy <= dy + $signed((NW+1)'(1));
            end else begin
              dx <= dx + $signed((NW+1)'(1));
            end
          end
        end
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (state == S_DONE && out_free) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {1'b0, res_cost};
      m_tuser <= kind;
    end
  end

endmodule

### verif/costmap_checker.sv
// ----------------------------------------------------------------------------
// costmap_checker
// watches the item, result and register channels of the costmap block,
// keeps its own copy of the core and cost grids and compares every result
// ----------------------------------------------------------------------------
module costmap_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [63:0]                 s_tdata,
  input  logic [1:0]                  s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [7:0]                  m_tdata,
  input  logic [1:0]                  m_tuser,
  input  logic                        cfg_we,
  input  logic [pcci_pkg::CFG_IW-1:0] cfg_index,
  input  logic [pcci_pkg::CFG_DW-1:0] cfg_data,
  output int                          errors,
  output int                          pending
);

  localparam int GRID_MAX = 64;
  localparam int WIN_MAX  = 16;

  typedef struct packed {
    logic [7:0] cost;
    logic [1:0] kind;
  } answer_t;

  answer_t          answers_due[$];
  bit               core_cells [GRID_MAX*GRID_MAX];
  pcci_pkg::cost_t  cost_cells [GRID_MAX*GRID_MAX];
  logic [9:0]  cell_mm;
  logic [6:0]  grid_n;
  logic signed [15:0] z_lo;
  logic signed [15:0] z_hi;
  logic [13:0] radius_mm;

  assign pending = answers_due.size();

  function automatic int grid_used();
    return (grid_n > GRID_MAX) ? GRID_MAX : int'(grid_n);
  endfunction

  function automatic longint cell_used();
    return (cell_mm == 0) ? 1 : longint'(cell_mm);
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  task automatic mark_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
    int     g;
    longint c, span, col, row;
    g    = grid_used();
    c    = cell_used();
    span = g * c;
    if (z < z_lo || z > z_hi) return;
    col = floor_div(2 * longint'(x) + span, 2 * c);
    row = floor_div(2 * longint'(y) + span, 2 * c);
    if (col < 0 || row < 0 || col >= g || row >= g) return;
    core_cells[row * GRID_MAX + col] = 1'b1;
  endtask

  task automatic rebuild_costs();
    int     g, n, dx, dy, x, y, nx, ny;
    longint c, r, d2, k;
    int     kern [2*WIN_MAX+1][2*WIN_MAX+1];
    g = grid_used();
    c = cell_used();
    r = radius_mm;
    n = int'((r + c - 1) / c);
    if (n > WIN_MAX) n = WIN_MAX;
    // smallest k with (k*r)^2 >= 10000*(c*d)^2 gives the floored linear cost
    for (dy = -n; dy <= n; dy++) begin
      for (dx = -n; dx <= n; dx++) begin
        d2 = dx * dx + dy * dy;
        kern[dy+n][dx+n] = -1;
        if (c * c * d2 <= r * r) begin
          k = 0;
          while (k < 100 && (k * r) * (k * r) < pcci_pkg::COST_SQ * c * c * d2) k++;
          kern[dy+n][dx+n] = 100 - int'(k);
        end
      end
    end
    foreach (cost_cells[i]) cost_cells[i] = '0;
    for (y = 0; y < g; y++) begin
      for (x = 0; x < g; x++) begin
        if (!core_cells[y*GRID_MAX+x]) continue;
        for (dy = -n; dy <= n; dy++) begin
          ny = y + dy;
          if (ny < 0 || ny >= g) continue;
          for (dx = -n; dx <= n; dx++) begin
            nx = x + dx;
            if (nx < 0 || nx >= g || kern[dy+n][dx+n] < 0) continue;
            if (kern[dy+n][dx+n] > cost_cells[ny*GRID_MAX+nx])
              cost_cells[ny*GRID_MAX+nx] = pcci_pkg::cost_t'(kern[dy+n][dx+n]);
          end
        end
      end
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    answer_t a;
    int      col, row, g;
    if (rst) begin
      foreach (core_cells[i]) core_cells[i] = 1'b0;
      foreach (cost_cells[i]) cost_cells[i] = '0;
      cell_mm   = 10'd50;
      grid_n    = 7'd50;
      z_lo      = 16'sd100;
      z_hi      = 16'sd1000;
      radius_mm = 14'd400;
      answers_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pcci_pkg::REG_CELL_SIZE: cell_mm   = cfg_data[9:0];
          pcci_pkg::REG_GRID:      grid_n    = cfg_data[6:0];
          pcci_pkg::REG_Z_MIN:     z_lo      = cfg_data;
          pcci_pkg::REG_Z_MAX:     z_hi      = cfg_data;
          pcci_pkg::REG_RADIUS:    radius_mm = cfg_data[13:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (answers_due.size() == 0) begin
          report("result kind with nothing outstanding", m_tuser, -1);
        end else begin
          a = answers_due.pop_front();
          if (m_tdata !== a.cost) report("cost", m_tdata, a.cost);
          if (m_tuser !== a.kind) report("done_kind", m_tuser, a.kind);
        end
      end
      if (s_tvalid && s_tready) begin
        a.kind = s_tuser;
        a.cost = '0;
        case (s_tuser)
          pcci_pkg::KIND_POINT:
            mark_point(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
          pcci_pkg::KIND_INFLATE: rebuild_costs();
          pcci_pkg::KIND_READ: begin
            col = s_tdata[53:48];
            row = s_tdata[59:54];
            g   = grid_used();
            if (col < g && row < g) a.cost = {1'b0, cost_cells[row*GRID_MAX+col]};
          end
          default: begin
            foreach (core_cells[i]) core_cells[i] = 1'b0;
            foreach (cost_cells[i]) cost_cells[i] = '0;
          end
        endcase
        if (s_tuser != pcci_pkg::KIND_POINT) answers_due.push_back(a);
      end
    end
  end

  initial errors = 0;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives points, inflates, reads and clears into the costmap block over a
// range of register settings with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module testbench;

  localparam longint CYCLE_LIMIT = 20000000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [63:0]       s_tdata = '0;   // x_mm, y_mm, z_mm, cell_col, cell_row
  logic [1:0]        s_tuser = '0;   // kind
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;        // cost
  logic [1:0]        m_tuser;        // done_kind
  logic              cfg_we = 1'b0;
  logic [pcci_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [pcci_pkg::CFG_DW-1:0] cfg_data = '0;
  int                errors;
  int                pending;
  longint            cycles = 0;
  bit                calm = 0;
  bit                hold_req = 0;
  int                cur_cell = 50;
  int                cur_grid = 50;
  int                cur_zlo = 100;
  int                cur_zhi = 1000;

  point_cloud_costmap_inflation_top dut (.*);

  costmap_checker chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        stall = 3000;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send(logic [1:0] kind, int x, int y, int z, int col, int row);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, 6'(row), 6'(col), 16'(z), 16'(y), 16'(x)};
    do @(posedge clk); while (!s_tready);
  endtask

  // block may still be placing a point when the last result arrives
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_cfg(int cell_sz, int grid, int zlo, int zhi, int radius);
    cfg_we <= 1'b1;
    cfg_index <= pcci_pkg::REG_CELL_SIZE; cfg_data <= 16'(cell_sz); @(posedge clk);
    cfg_index <= pcci_pkg::REG_GRID;      cfg_data <= 16'(grid);    @(posedge clk);
    cfg_index <= pcci_pkg::REG_Z_MIN;     cfg_data <= 16'(zlo);     @(posedge clk);
    cfg_index <= pcci_pkg::REG_Z_MAX;     cfg_data <= 16'(zhi);     @(posedge clk);
    cfg_index <= pcci_pkg::REG_RADIUS;    cfg_data <= 16'(radius);  @(posedge clk);
    cfg_we <= 1'b0;
    cur_cell = (cell_sz == 0) ? 1 : cell_sz;
    cur_grid = (grid > 64) ? 64 : grid;
    cur_zlo  = zlo;
    cur_zhi  = zhi;
  endtask

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int pick_coord();
    int half;
    half = cur_grid * cur_cell / 2 + cur_cell;
    if ($urandom_range(0, 9) < 8) return clip16($urandom_range(0, 2 * half) - half);
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int pick_z();
    if (cur_zlo <= cur_zhi && $urandom_range(0, 9) < 8)
      return $urandom_range(0, cur_zhi - cur_zlo) + cur_zlo;
    return int'($signed(16'($urandom)));
  endfunction

  task automatic add_points(int count);
    repeat (count) send(pcci_pkg::KIND_POINT, pick_coord(), pick_coord(), pick_z(), 0, 0);
  endtask

  task automatic read_cells(int count);
    int col, row;
    repeat (count) begin
      if (cur_grid > 0 && $urandom_range(0, 3) != 0) begin
        col = $urandom_range(0, cur_grid - 1);
        row = $urandom_range(0, cur_grid - 1);
      end else begin
        col = $urandom_range(0, 63);
        row = $urandom_range(0, 63);
      end
      send(pcci_pkg::KIND_READ, 0, 0, 0, col, row);
    end
  endtask

  task automatic run_phase(int cell_sz, int grid, int zlo, int zhi, int radius, int npts,
                           int nreads);
    drain();
    write_cfg(cell_sz, grid, zlo, zhi, radius);
    calm = ($urandom_range(0, 3) == 0);
    send(pcci_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
    add_points(npts);
    send(pcci_pkg::KIND_INFLATE, 0, 0, 0, 0, 0);
    read_cells(nreads);
    // stale costs: points after an inflate stay invisible until the next one
    add_points(npts / 4);
    read_cells(nreads / 3);
    send(pcci_pkg::KIND_INFLATE, 0, 0, 0, 0, 0);
    read_cells(nreads / 3);
  endtask

  initial begin
    int r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_cfg(50, 50, 100, 1000, 400);

    // directed: grid edges, height band edges, far points, reads in and out
    send(pcci_pkg::KIND_POINT, 0, 0, 500, 0, 0);
    send(pcci_pkg::KIND_POINT, -1250, -1250, 100, 0, 0);
    send(pcci_pkg::KIND_POINT, 1249, 1249, 1000, 0, 0);
    send(pcci_pkg::KIND_POINT, 1250, 0, 500, 0, 0);
    send(pcci_pkg::KIND_POINT, -1251, 0, 500, 0, 0);
    send(pcci_pkg::KIND_POINT, 0, 0, 99, 0, 0);
    send(pcci_pkg::KIND_POINT, 0, 0, 1001, 0, 0);
    send(pcci_pkg::KIND_POINT, 32767, -32768, 500, 0, 0);
    send(pcci_pkg::KIND_POINT, -25, -25, 500, 0, 0);
    send(pcci_pkg::KIND_INFLATE, 0, 0, 0, 0, 0);
    send(pcci_pkg::KIND_READ, 0, 0, 0, 25, 25);
    send(pcci_pkg::KIND_READ, 0, 0, 0, 26, 25);
    send(pcci_pkg::KIND_READ, 0, 0, 0, 25, 33);
    send(pcci_pkg::KIND_READ, 0, 0, 0, 0, 0);
    send(pcci_pkg::KIND_READ, 0, 0, 0, 49, 49);
    send(pcci_pkg::KIND_READ, 0, 0, 0, 50, 0);
    send(pcci_pkg::KIND_READ, 0, 0, 0, 63, 63);
    send(pcci_pkg::KIND_POINT, 1000, 1000, 500, 0, 0);
    send(pcci_pkg::KIND_READ, 0, 0, 0, 45, 45);
    send(pcci_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
    send(pcci_pkg::KIND_READ, 0, 0, 0, 25, 25);
    send(pcci_pkg::KIND_INFLATE, 0, 0, 0, 0, 0);
    send(pcci_pkg::KIND_READ, 0, 0, 0, 45, 45);

    // extremes: tiny cells, huge cells with the widest window, zero cell,
    // oversize grid, zero radius, empty grid, single cell, inverted band
    run_phase(1, 64, -32768, 32767, 3, 60, 30);
    run_phase(1000, 64, -32768, 32767, 16000, 12, 30);
    run_phase(0, 127, -32768, 32767, 0, 60, 30);
    run_phase(100, 0, -1000, 1000, 300, 30, 20);
    run_phase(100, 1, -1000, 1000, 300, 30, 20);
    run_phase(40, 32, 500, -500, 120, 30, 20);

    // long hold-off on results while reads keep coming
    drain();
    hold_req = 1;
    calm = 1;
    read_cells(40);

    repeat (4) begin
      r = $urandom_range(0, 3);
      run_phase($urandom_range(10, 200), $urandom_range(8, 40), -$urandom_range(0, 500),
                $urandom_range(0, 2000), $urandom_range(1, 200 * (r + 1)), 60, 30);
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/pcci_pkg.sv
hdl/point_cloud_costmap_inflation_top.sv
verif/costmap_checker.sv
verif/testbench.sv
